/* src/lir_pkg.sv */
package lir_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic emit_lerp;
    logic emit_tail;
    logic close_phase;
    logic clear;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic have_prior;
    logic pos_below_one;
    logic last;
    logic out_free;
  } status_t;

endpackage

/* src/lir_in_if.sv */
interface lir_in_if #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          in_last;

  modport source(output valid, in_sample, in_last, input ready);
  modport sink(input valid, in_sample, in_last, output ready);
endinterface

/* src/lir_out_if.sv */
interface lir_out_if #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          run_end;
  logic                          stream_end;

  modport source(output valid, out_sample, run_end, stream_end, input ready);
  modport sink(input valid, out_sample, run_end, stream_end, output ready);
endinterface

/* src/linear_interp_resampler.sv */
// Linear-interpolation sample rate converter. Each accepted sample closes the
// span from the previous sample; every output position in that span (advancing
// by step_ratio, unsigned with FRAC_BITS fraction bits, clamped to 1/32..64)
// gives prior + round((cur - prior) * frac), saturated. The first sample of a
// stream only primes the block; its last sample also repeats itself for the
// positions left below the stream length, then the stream state clears.
// Steps: an item is loaded, then each interpolated output runs decide, multiply
// and output register, all on one shared multiplier; a last sample then emits
// its repeated tail outputs and clears. Emits wait while the output register is
// full and results.ready is low. The final result of an item may still sit in
// the output register while the next one is taken.
module linear_interp_resampler #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [FRAC_BITS+6:0] cfg_wdata,
  lir_in_if.sink               samples,
  lir_out_if.source            results
);
  import lir_pkg::*;

  cmd_t    cmd;
  status_t sts;

  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lir_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (samples.in_sample),
    .in_last    (samples.in_last),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_sample (results.out_sample),
    .run_end    (results.run_end),
    .stream_end (results.stream_end)
  );

`ifndef SYNTHESIS
  a_stream_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.stream_end |-> results.run_end)
    else $error("stream_end without run_end");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_lerp || cmd.emit_tail) |-> sts.out_free)
    else $error("output register overwritten");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("new sample taken while one is in progress");

  a_clear_resets_stream: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> !sts.have_prior && sts.pos_below_one)
    else $error("stream state not cleared");
`endif

endmodule

/* src/lir_ctrl.sv */
module lir_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lir_pkg::status_t sts,
  output lir_pkg::cmd_t    cmd
);
  import lir_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_TAIL   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.have_prior && sts.pos_below_one) begin
          state_next = S_MUL;
        end else begin
          // interpolation span done: rebase position, then tail or finish
          cmd.close_phase = 1'b1;
          state_next      = sts.last ? S_TAIL : S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_lerp = 1'b1;
          state_next    = S_DECIDE;
        end
      end
      S_TAIL: begin
        if (!sts.pos_below_one) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_tail = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/lir_datapath.sv */
module lir_datapath #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [FRAC_BITS+6:0]          cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last,
  input  lir_pkg::cmd_t                 cmd,
  output lir_pkg::status_t              sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          run_end,
  output logic                          stream_end
);
  import lir_pkg::*;

  localparam int PW     = FRAC_BITS + 7;
  localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int SW     = SAMPLE_BITS + 2;

  localparam logic [PW-1:0] ONE_POS  = PW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] TWO_POS  = PW'(1) << (FRAC_BITS + 1);
  localparam logic [PW-1:0] STEP_MIN = PW'(1) << (FRAC_BITS - 5);
  localparam logic [PW-1:0] STEP_MAX = PW'(1) << (FRAC_BITS + 6);
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_HI = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {3'b111, {(SAMPLE_BITS-1){1'b0}}};

  logic [PW-1:0]                 step_ratio;
  logic [PW-1:0]                 step_eff;
  logic [PW-1:0]                 pos;
  logic [PW-1:0]                 pos_adv;
  logic                          have_prior;
  logic                          last_q;
  logic signed [SAMPLE_BITS-1:0] cur;
  logic signed [SAMPLE_BITS-1:0] prior;
  logic signed [PROD_W-1:0]      prod;
  logic signed [PROD_W-1:0]      prod_full;
  logic signed [PROD_W-1:0]      prod_rnd;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [SW-1:0]          interp;
  logic signed [SAMPLE_BITS-1:0] interp_sat;
  logic                          lerp_final;
  logic                          tail_final;
  logic                          emit;

  always_comb begin
    if (step_ratio < STEP_MIN) begin
      step_eff = STEP_MIN;
    end else if (step_ratio > STEP_MAX) begin
      step_eff = STEP_MAX;
    end else begin
      step_eff = step_ratio;
    end
  end

  assign pos_adv = pos + step_eff;

  assign diff      = $signed({cur[SAMPLE_BITS-1], cur}) - $signed({prior[SAMPLE_BITS-1], prior});
  assign prod_full = PROD_W'(diff) * PROD_W'($signed({1'b0, pos[FRAC_BITS-1:0]}));

  // round half up, then floor via arithmetic part-select
  assign prod_rnd = prod + HALF;
  assign interp   = $signed({{2{prior[SAMPLE_BITS-1]}}, prior})
                  + $signed(prod_rnd[PROD_W-1:FRAC_BITS]);

  always_comb begin
    if (interp > SAT_HI) begin
      interp_sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (interp < SAT_LO) begin
      interp_sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      interp_sat = interp[SAMPLE_BITS-1:0];
    end
  end

  // last interpolated output of an item is also the stream's last when no tail follows
  assign tail_final = (pos_adv >= ONE_POS);
  assign lerp_final = tail_final && !(last_q && (pos_adv < TWO_POS));
  assign emit       = cmd.emit_lerp || cmd.emit_tail;

  assign sts.have_prior    = have_prior;
  assign sts.pos_below_one = (pos < ONE_POS);
  assign sts.last          = last_q;
  assign sts.out_free      = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio <= ONE_POS;
      pos        <= '0;
      have_prior <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        step_ratio <= cfg_wdata;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        pos <= pos_adv;
      end
      if (cmd.close_phase) begin
        if (have_prior) begin
          pos <= pos - ONE_POS;
        end
        if (!last_q) begin
          have_prior <= 1'b1;
        end
      end
      if (cmd.clear) begin
        pos        <= '0;
        have_prior <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur    <= in_sample;
      last_q <= in_last;
    end
    if (cmd.mul) begin
      prod <= prod_full;
    end
    if (cmd.close_phase && !last_q) begin
      prior <= cur;
    end
    if (cmd.clear) begin
      prior <= '0;
    end
    if (cmd.emit_lerp) begin
      out_sample <= interp_sat;
      run_end    <= lerp_final;
      stream_end <= lerp_final && last_q;
    end else if (cmd.emit_tail) begin
      out_sample <= cur;
      run_end    <= tail_final;
      stream_end <= tail_final;
    end
  end

endmodule

/* tb/tb_linear_interp_resampler.sv */
import lir_pkg::*;

class lerp_tracker;
  localparam int SW = SAMPLE_BITS_DEF;
  localparam int FW = FRAC_BITS_DEF;
  localparam int unsigned ONE_POS = 1 << FW;
  localparam int unsigned STEP_LO = 1 << (FW - 5);
  localparam int unsigned STEP_HI = 1 << (FW + 6);
  localparam int MAX_OUT = 64;
  localparam longint SAT_HI = (longint'(1) << (SW - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef struct {
    logic signed [SW-1:0] sample;
    logic                 run_end;
    logic                 stream_end;
  } out_rec_t;

  int unsigned          step_val;
  logic signed [SW-1:0] prior;
  bit                   have_prior;
  int unsigned          next_pos;
  out_rec_t             pending_outputs[$];
  int                   mismatches;
  int                   checked;

  function new();
    step_val   = ONE_POS;
    prior      = '0;
    have_prior = 1'b0;
    next_pos   = 0;
    mismatches = 0;
    checked    = 0;
  endfunction

  function void set_step(logic [FW+6:0] v);
    step_val = 32'(v);
  endfunction

  function int outstanding();
    return pending_outputs.size();
  endfunction

  function logic signed [SW-1:0] blend(logic signed [SW-1:0] a, logic signed [SW-1:0] b,
                                       int unsigned frac);
    longint d;
    longint q;
    longint r;
    d = longint'(b) - longint'(a);
    // add one half, then floor via arithmetic shift
    q = (d * longint'(frac) + longint'(ONE_POS >> 1)) >>> FW;
    r = longint'(a) + q;
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return r[SW-1:0];
  endfunction

  function void push_out(logic signed [SW-1:0] v);
    out_rec_t rec;
    rec.sample     = v;
    rec.run_end    = 1'b0;
    rec.stream_end = 1'b0;
    pending_outputs.push_back(rec);
  endfunction

  // Accepted input transfer: extend the expected output list.
  function void take_sample(logic signed [SW-1:0] cur, logic last);
    int unsigned st;
    int n;
    st = step_val;
    n  = 0;
    if (st < STEP_LO) st = STEP_LO;
    if (st > STEP_HI) st = STEP_HI;
    if (have_prior) begin
      while (next_pos < ONE_POS && n < MAX_OUT) begin
        push_out(blend(prior, cur, next_pos));
        n++;
        next_pos += st;
      end
      next_pos -= ONE_POS;
    end
    if (last) begin
      // tail: repeat the final sample for positions left in the stream
      while (next_pos < ONE_POS && n < MAX_OUT) begin
        push_out(cur);
        n++;
        next_pos += st;
      end
      if (n > 0) pending_outputs[pending_outputs.size()-1].stream_end = 1'b1;
      prior      = '0;
      have_prior = 1'b0;
      next_pos   = 0;
    end else begin
      prior      = cur;
      have_prior = 1'b1;
    end
    if (n > 0) pending_outputs[pending_outputs.size()-1].run_end = 1'b1;
  endfunction

  // Accepted output transfer: compare with the oldest expectation.
  function void match_output(logic signed [SW-1:0] s, logic re, logic se);
    out_rec_t exp_rec;
    checked++;
    if (pending_outputs.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected output: sample %0d run_end %0b stream_end %0b", s, re, se);
      mismatches++;
      return;
    end
    exp_rec = pending_outputs.pop_front();
    if (s !== exp_rec.sample || re !== exp_rec.run_end || se !== exp_rec.stream_end) begin
      if (mismatches < 10)
        $display("mismatch: expected sample %0d run_end %0b stream_end %0b, got %0d %0b %0b",
                 exp_rec.sample, exp_rec.run_end, exp_rec.stream_end, s, re, se);
      mismatches++;
    end
  endfunction
endclass

module tb_linear_interp_resampler;
  localparam int SW = SAMPLE_BITS_DEF;
  localparam int FW = FRAC_BITS_DEF;
  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam int IDLE_WAIT = 16;
  localparam int RANDOM_ITEMS = 180;

  logic          clk;
  logic          rst;
  logic          cfg_we;
  logic [FW+6:0] cfg_wdata;

  lir_in_if  #(.SAMPLE_BITS(SW)) in_ch();
  lir_out_if #(.SAMPLE_BITS(SW)) out_ch();

  linear_interp_resampler #(.SAMPLE_BITS(SW), .FRAC_BITS(FW)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .samples(in_ch),
    .results(out_ch)
  );

  lerp_tracker tracker;
  longint      cycle_count = 0;
  bit          calm = 1'b0;
  int          hold_left = 0;
  int          items_sent = 0;
  int          streams_sent = 0;
  int          steps_used = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      tracker.match_output(out_ch.out_sample, out_ch.run_end, out_ch.stream_end);
  end

  // result-side backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0) begin
        if (calm) begin
          out_ch.ready <= 1'b1;
          hold_left = $urandom_range(4, 12);
        end else begin
          out_ch.ready <= ($urandom_range(0, 2) != 0);
          hold_left = ($urandom_range(0, 19) < 16) ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 60);
        end
      end else begin
        hold_left--;
      end
    end
  end

  function int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function logic signed [SW-1:0] pick_sample();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return SW'($signed($urandom_range(0, 255)) - 128);
      default: return raw[SW-1:0];
    endcase
  endfunction

  function logic [FW+6:0] pick_step();
    case ($urandom_range(0, 19))
      0: return (FW+7)'($urandom_range(0, 2047));
      1: return (FW+7)'($urandom_range(4194305, 8388607));
      2, 3: return (FW+7)'($urandom_range(262144, 4194304));
      4, 5, 6, 7: return (FW+7)'($urandom_range(2048, 16384));
      default: return (FW+7)'($urandom_range(16384, 262144));
    endcase
  endfunction

  task automatic send_sample(logic signed [SW-1:0] s, logic l);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_sample <= s;
    in_ch.in_last   <= l;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.take_sample(s, l);
    items_sent++;
    if (l) streams_sent++;
  endtask

  // step register is only touched once every pending output has drained
  task automatic write_step(logic [FW+6:0] v);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    tracker.set_step(v);
    steps_used++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_stream(int len);
    for (int i = 0; i < len; i++)
      send_sample(pick_sample(), i == len - 1);
  endtask

  initial begin
    int random_done;
    int nstreams;
    tracker = new();
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.in_sample = '0;
    in_ch.in_last   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset step of 1.0, full-scale swings, single-sample stream
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd200, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd12345, 1'b1);

    // smallest step: 32 interpolated plus 32 tail outputs on the last sample
    write_step(23'd2048);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd5, 1'b1);

    // below range clamps to smallest step
    write_step(23'd0);
    send_sample(-16'sd1, 1'b1);

    // largest step: last sample skips all positions and yields nothing
    write_step(23'd4194304);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd3, 1'b1);

    // above range clamps to largest step
    write_step(23'h7fffff);
    send_sample(16'sd7, 1'b1);

    write_step(23'd98304);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd3, 1'b0);
    send_sample(16'sd3, 1'b1);

    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      write_step(pick_step());
      calm = ($urandom_range(0, 3) == 0);
      nstreams = $urandom_range(1, 3);
      for (int k = 0; k < nstreams; k++) begin
        int len;
        len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 16);
        send_stream(len);
        random_done += len;
      end
    end
    calm = 1'b0;

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d samples in %0d streams over %0d step settings", items_sent,
             streams_sent, steps_used + 1);
    $display("Checked %0d output transfers, %0d mismatches", tracker.checked,
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
